// ===== rtl/chi_pkg.sv =====
// ----------------------------------------------------------------------------
// chi_pkg
// Shared widths, types and helpers of the cubic Hermite interpolator.
// ----------------------------------------------------------------------------
package chi_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   localparam int DW    = DATA_WIDTH;
   localparam int FB    = FRAC_BITS;
   // coefficient / accumulator width, covers the worst Horner intermediate
   localparam int ACC_W = 2 * DW - FB + 6;
   localparam int QW    = DW + 1;      // quotient field width, the bits produced by the rate divider row
   localparam int SW    = FB + 1;      // normalised position, 0..2^FB

   typedef logic signed [DW-1:0]    word_type;
   typedef logic signed [ACC_W-1:0] acc_type;

   typedef struct packed {
      logic [DW-1:0] rem;
      logic [QW-1:0] quot;
   } div_type;

   localparam word_type WORD_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(DW-1){1'b0}}};

   function automatic word_type sat_acc(input acc_type v);
      acc_type hi;
      acc_type lo;
      hi = acc_type'(WORD_MAX);
      lo = acc_type'(WORD_MIN);
      if (v > hi) begin
         return WORD_MAX;
      end else if (v < lo) begin
         return WORD_MIN;
      end
      return v[DW-1:0];
   endfunction

endpackage

// ===== rtl/chi_if.sv =====
// ----------------------------------------------------------------------------
// chi_if
// Request and response channels of the cubic Hermite interpolator.
// ----------------------------------------------------------------------------
interface chi_req_if;
   logic              valid;
   logic              ready;
   chi_pkg::word_type seg_start;
   chi_pkg::word_type seg_end;
   chi_pkg::word_type val_start;
   chi_pkg::word_type val_end;
   chi_pkg::word_type slope_start;
   chi_pkg::word_type slope_end;
   chi_pkg::word_type query_point;
   chi_pkg::word_type query_rate;

   modport source (output valid, seg_start, seg_end, val_start, val_end, slope_start,
                   slope_end, query_point, query_rate, input ready);
   modport sink   (input valid, seg_start, seg_end, val_start, val_end, slope_start,
                   slope_end, query_point, query_rate, output ready);
endinterface

interface chi_rsp_if;
   logic              valid;
   logic              ready;
   chi_pkg::word_type value_out;
   chi_pkg::word_type rate_out;
   logic              bad_segment;

   modport source (output valid, value_out, rate_out, bad_segment, input ready);
   modport sink   (input valid, value_out, rate_out, bad_segment, output ready);
endinterface

// ===== rtl/chi_div_cell.sv =====
// ----------------------------------------------------------------------------
// chi_div_cell
// One restoring-division cell: shifts in a dividend bit, yields a quotient bit.
// ----------------------------------------------------------------------------
module chi_div_cell (
   input  logic                       clock,
   input  logic                       en,
   input  chi_pkg::div_type           cur_i,
   input  logic                       bit_i,
   input  logic [chi_pkg::DW-1:0]     div_i,
   output chi_pkg::div_type           nxt_o
);

   logic [chi_pkg::DW:0] shifted;
   logic [chi_pkg::DW:0] diff;
   logic                 ge;
   chi_pkg::div_type     nxt_in;
   chi_pkg::div_type     nxt_ff;

   always_comb begin
      shifted     = {cur_i.rem, bit_i};
      diff        = shifted - {1'b0, div_i};
      ge          = (shifted >= {1'b0, div_i});
      nxt_in.rem  = ge ? diff[chi_pkg::DW-1:0] : shifted[chi_pkg::DW-1:0];
      nxt_in.quot = {cur_i.quot[chi_pkg::QW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nxt_ff <= nxt_in;
      end
   end

   assign nxt_o = nxt_ff;

endmodule

// ===== rtl/chi_poly.sv =====
// ----------------------------------------------------------------------------
// chi_poly
// Six-stage Horner evaluation of the cubic and of its derivative polynomial.
// ----------------------------------------------------------------------------
module chi_poly (
   input  logic                   clock,
   input  logic                   en,
   input  chi_pkg::acc_type       a0_i,
   input  chi_pkg::acc_type       a1_i,
   input  chi_pkg::acc_type       a2_i,
   input  chi_pkg::word_type      y1_i,
   input  logic [chi_pkg::SW-1:0] s_i,
   output chi_pkg::acc_type       y_o,
   output chi_pkg::acc_type       d_o
);

   localparam int MW = chi_pkg::ACC_W + chi_pkg::SW + 1;

   logic signed [chi_pkg::SW:0] s_sgn;
   logic signed [MW-1:0]        m0_ff, md0_ff, m1_ff, md1_ff, m2_ff;
   chi_pkg::acc_type            a0x3;
   chi_pkg::acc_type            t1_ff, td1_ff, t2_ff, d_ff, d5_ff, y_ff, d6_ff;
   chi_pkg::acc_type            a1_1_ff, a2_1_ff, a2_2_ff, a2_3_ff;
   chi_pkg::word_type           y1_1_ff, y1_2_ff, y1_3_ff, y1_4_ff, y1_5_ff;
   logic [chi_pkg::SW-1:0]      s_1_ff, s_2_ff, s_3_ff, s_4_ff;

   assign s_sgn = $signed({1'b0, s_i});
   assign a0x3  = (a0_i <<< 1) + a0_i;

   always_ff @(posedge clock) begin
      if (en) begin
         // stage 1
         m0_ff   <= a0_i * s_sgn;
         md0_ff  <= a0x3 * s_sgn;
         a1_1_ff <= a1_i;
         a2_1_ff <= a2_i;
         y1_1_ff <= y1_i;
         s_1_ff  <= s_i;
         // stage 2
         t1_ff   <= chi_pkg::acc_type'(m0_ff >>> chi_pkg::FB) + a1_1_ff;
         td1_ff  <= chi_pkg::acc_type'(md0_ff >>> chi_pkg::FB) + (a1_1_ff <<< 1);
         a2_2_ff <= a2_1_ff;
         y1_2_ff <= y1_1_ff;
         s_2_ff  <= s_1_ff;
         // stage 3
         m1_ff   <= t1_ff * $signed({1'b0, s_2_ff});
         md1_ff  <= td1_ff * $signed({1'b0, s_2_ff});
         a2_3_ff <= a2_2_ff;
         y1_3_ff <= y1_2_ff;
         s_3_ff  <= s_2_ff;
         // stage 4
         t2_ff   <= chi_pkg::acc_type'(m1_ff >>> chi_pkg::FB) + a2_3_ff;
         d_ff    <= chi_pkg::acc_type'(md1_ff >>> chi_pkg::FB) + a2_3_ff;
         y1_4_ff <= y1_3_ff;
         s_4_ff  <= s_3_ff;
         // stage 5
         m2_ff   <= t2_ff * $signed({1'b0, s_4_ff});
         d5_ff   <= d_ff;
         y1_5_ff <= y1_4_ff;
         // stage 6
         y_ff    <= chi_pkg::acc_type'(m2_ff >>> chi_pkg::FB) + chi_pkg::acc_type'(y1_5_ff);
         d6_ff   <= d5_ff;
      end
   end

   assign y_o = y_ff;
   assign d_o = d6_ff;

endmodule

// ===== rtl/cubic_hermite_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// cubic_hermite_interpolator_top
// Pipelined cubic Hermite segment interpolator, signed Q16.16.
//
//   channel  dir  payload
//   req_ch   in   seg_start seg_end val_start val_end slope_start slope_end
//                 query_point query_rate
//   rsp_ch   out  value_out rate_out bad_segment
//
// One transaction per cycle unless the response side holds the pipeline.
// The pipeline contains two rows of restoring-division cells: FB + 1 cells
// for the position s and DW + 1 cells for the rate quotient.
// Synchronous reset empties the pipeline; no clearing pass.
// The whole pipeline holds while the response register is full and not taken.
// ----------------------------------------------------------------------------
module cubic_hermite_interpolator_top (
   input  logic         clock,
   input  logic         reset,
   chi_req_if.sink      req_ch,
   chi_rsp_if.source    rsp_ch
);

   localparam int DW   = chi_pkg::DW;
   localparam int FB   = chi_pkg::FB;
   localparam int AW   = chi_pkg::ACC_W;
   localparam int PW   = 2 * DW + 1;
   localparam int LO_W = AW / 2;
   localparam int HI_W = AW - LO_W;
   localparam int NW   = DW + AW;
   localparam int LAT  = DW + FB + 15;

   typedef logic signed [NW-1:0] wide_type;

   typedef struct packed {
      logic              bad;
      logic [DW-1:0]     h;
      chi_pkg::word_type dx;
      chi_pkg::word_type y1;
      chi_pkg::acc_type  a0;
      chi_pkg::acc_type  a1;
      chi_pkg::acc_type  a2;
   } sa_type;

   typedef struct packed {
      logic              bad;
      logic [DW-1:0]     h;
      chi_pkg::word_type dx;
   } pd_type;

   typedef struct packed {
      logic              bad;
      logic [DW-1:0]     h;
      chi_pkg::word_type val;
      logic              neg;
   } rc_type;

   typedef struct packed {
      logic              bad;
      logic [DW-1:0]     h;
      chi_pkg::word_type val;
      logic              neg;
      logic              ovf;
      logic [DW:0]       low;
   } rb_type;

   logic               en;
   logic [LAT-1:0]     vld_ff;

   // stage 0
   logic               bad_c;
   logic [DW:0]        hsub;
   chi_pkg::word_type  xc;
   logic [DW-1:0]      usub;
   logic               bad0_ff;
   logic [DW-1:0]      h0_ff, u0_ff;
   chi_pkg::word_type  y1_0_ff, y2_0_ff, m1_0_ff, m2_0_ff, dx0_ff;

   // position divider row
   chi_pkg::div_type   s_start;
   chi_pkg::div_type   scell [0:FB];
   sa_type             sa_ff [0:FB];
   logic signed [PW-1:0] pm1_ff, pm2_ff;
   chi_pkg::word_type  y2_1_ff;
   chi_pkg::acc_type   p1, p2, y1e, y2e;
   logic [chi_pkg::SW-1:0] s_pos;

   // polynomial and rate front
   chi_pkg::acc_type   poly_y, poly_d;
   pd_type             pd_ff [0:5];
   logic signed [DW+LO_W:0]  pplo_ff;
   logic signed [DW+HI_W-1:0] pphi_ff;
   rc_type             rc_ff [1:4];
   wide_type           n_ff;
   logic [NW-1:0]      mag_ff, magc_ff;
   logic [DW-1:0]      hm1;
   logic [NW-DW-2:0]   top;
   logic               ovf_c;
   rb_type             r5_ff;
   chi_pkg::div_type   r5_div;
   logic [DW-1:0]      r5_rem_ff;

   // rate divider row
   chi_pkg::div_type   rcell [0:DW];
   rb_type             rb_ff [0:DW];

   // output register
   chi_pkg::acc_type   rq;
   chi_pkg::word_type  rate_c;
   chi_pkg::word_type  value_ff, rate_ff;
   logic               bad_ff;

   assign en           = !vld_ff[LAT-1] || rsp_ch.ready;
   assign req_ch.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_ch.valid};
      end
   end

   // clamp and offset
   always_comb begin
      bad_c = (req_ch.seg_end <= req_ch.seg_start);
      hsub  = {req_ch.seg_end[DW-1], req_ch.seg_end}
            - {req_ch.seg_start[DW-1], req_ch.seg_start};
      if (req_ch.query_point < req_ch.seg_start) begin
         xc = req_ch.seg_start;
      end else if (req_ch.query_point > req_ch.seg_end) begin
         xc = req_ch.seg_end;
      end else begin
         xc = req_ch.query_point;
      end
      usub = xc - req_ch.seg_start;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bad0_ff <= bad_c;
         h0_ff   <= hsub[DW-1:0];
         u0_ff   <= usub;
         y1_0_ff <= req_ch.val_start;
         y2_0_ff <= req_ch.val_end;
         m1_0_ff <= req_ch.slope_start;
         m2_0_ff <= req_ch.slope_end;
         dx0_ff  <= req_ch.query_rate;
      end
   end

   // s = floor(u * 2^FB / h); u <= h, so the first cell sees u itself
   assign s_start.rem  = u0_ff >> 1;
   assign s_start.quot = '0;

   for (genvar k = 0; k <= FB; k++) begin : g_scell
      if (k == 0) begin : g_first
         chi_div_cell u_cell (
            .clock (clock), .en (en), .cur_i (s_start), .bit_i (u0_ff[0]),
            .div_i (h0_ff), .nxt_o (scell[k])
         );
      end else begin : g_next
         chi_div_cell u_cell (
            .clock (clock), .en (en), .cur_i (scell[k-1]), .bit_i (1'b0),
            .div_i (sa_ff[k-1].h), .nxt_o (scell[k])
         );
      end
   end

   // Hermite coefficients alongside the first two cells
   always_comb begin
      p1  = chi_pkg::acc_type'(pm1_ff >>> FB);
      p2  = chi_pkg::acc_type'(pm2_ff >>> FB);
      y1e = chi_pkg::acc_type'(sa_ff[0].y1);
      y2e = chi_pkg::acc_type'(y2_1_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pm1_ff      <= m1_0_ff * $signed({1'b0, h0_ff});
         pm2_ff      <= m2_0_ff * $signed({1'b0, h0_ff});
         y2_1_ff     <= y2_0_ff;
         sa_ff[0]    <= '{bad: bad0_ff, h: h0_ff, dx: dx0_ff, y1: y1_0_ff,
                          a0: '0, a1: '0, a2: '0};
         sa_ff[1]    <= '{bad: sa_ff[0].bad, h: sa_ff[0].h, dx: sa_ff[0].dx,
                          y1: sa_ff[0].y1,
                          a0: ((y1e - y2e) <<< 1) + p1 + p2,
                          a1: ((y2e - y1e) <<< 1) + (y2e - y1e) - (p1 <<< 1) - p2,
                          a2: p1};
         for (int i = 2; i <= FB; i++) begin
            sa_ff[i] <= sa_ff[i-1];
         end
      end
   end

   assign s_pos = scell[FB].quot[chi_pkg::SW-1:0];

   chi_poly u_poly (
      .clock (clock), .en (en),
      .a0_i (sa_ff[FB].a0), .a1_i (sa_ff[FB].a1), .a2_i (sa_ff[FB].a2),
      .y1_i (sa_ff[FB].y1), .s_i (s_pos),
      .y_o (poly_y), .d_o (poly_d)
   );

   assign hm1 = rc_ff[3].h - 1'b1;
   assign top = magc_ff[NW-1:DW+1];
   assign ovf_c = (top >= {{(NW-2*DW-1){1'b0}}, rc_ff[4].h});

   // rate = floor(dx * d / h): split product, sign-magnitude, then divider row
   always_ff @(posedge clock) begin
      if (en) begin
         pd_ff[0] <= '{bad: sa_ff[FB].bad, h: sa_ff[FB].h, dx: sa_ff[FB].dx};
         for (int i = 1; i < 6; i++) begin
            pd_ff[i] <= pd_ff[i-1];
         end
         pplo_ff   <= pd_ff[5].dx * $signed({1'b0, poly_d[LO_W-1:0]});
         pphi_ff   <= pd_ff[5].dx * $signed(poly_d[AW-1:LO_W]);
         rc_ff[1]  <= '{bad: pd_ff[5].bad, h: pd_ff[5].h,
                        val: chi_pkg::sat_acc(poly_y), neg: 1'b0};
         n_ff      <= (wide_type'(pphi_ff) <<< LO_W) + wide_type'(pplo_ff);
         rc_ff[2]  <= rc_ff[1];
         mag_ff    <= n_ff[NW-1] ? (~n_ff + 1'b1) : n_ff;
         rc_ff[3]  <= '{bad: rc_ff[2].bad, h: rc_ff[2].h, val: rc_ff[2].val,
                        neg: n_ff[NW-1]};
         // round the magnitude up for a negative dividend
         magc_ff   <= mag_ff + (rc_ff[3].neg ? {{(NW-DW){1'b0}}, hm1} : '0);
         rc_ff[4]  <= rc_ff[3];
         r5_rem_ff <= ovf_c ? '0 : top[DW-1:0];
         r5_ff     <= '{bad: rc_ff[4].bad, h: rc_ff[4].h, val: rc_ff[4].val,
                        neg: rc_ff[4].neg, ovf: ovf_c, low: magc_ff[DW:0]};
         rb_ff[0]  <= r5_ff;
         for (int i = 1; i <= DW; i++) begin
            rb_ff[i] <= rb_ff[i-1];
         end
      end
   end

   assign r5_div.rem  = r5_rem_ff;
   assign r5_div.quot = '0;

   for (genvar c = 0; c <= DW; c++) begin : g_rcell
      if (c == 0) begin : g_first
         chi_div_cell u_cell (
            .clock (clock), .en (en), .cur_i (r5_div), .bit_i (r5_ff.low[DW]),
            .div_i (r5_ff.h), .nxt_o (rcell[c])
         );
      end else begin : g_next
         chi_div_cell u_cell (
            .clock (clock), .en (en), .cur_i (rcell[c-1]), .bit_i (rb_ff[c-1].low[DW-c]),
            .div_i (rb_ff[c-1].h), .nxt_o (rcell[c])
         );
      end
   end

   always_comb begin
      rq = chi_pkg::acc_type'({1'b0, rcell[DW].quot});
      if (rb_ff[DW].neg) begin
         rq = -rq;
      end
      if (rb_ff[DW].ovf) begin
         rate_c = rb_ff[DW].neg ? chi_pkg::WORD_MIN : chi_pkg::WORD_MAX;
      end else begin
         rate_c = chi_pkg::sat_acc(rq);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bad_ff   <= rb_ff[DW].bad;
         value_ff <= rb_ff[DW].bad ? '0 : rb_ff[DW].val;
         rate_ff  <= rb_ff[DW].bad ? '0 : rate_c;
      end
   end

   assign rsp_ch.valid       = vld_ff[LAT-1];
   assign rsp_ch.value_out   = value_ff;
   assign rsp_ch.rate_out    = rate_ff;
   assign rsp_ch.bad_segment = bad_ff;

   a_bad_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.bad_segment |-> rsp_ch.value_out == '0 && rsp_ch.rate_out == '0)
      else $error("bad segment with non-zero result");

   a_stall_only : assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> rsp_ch.valid && !rsp_ch.ready)
      else $error("request stalled without a blocked response");

   a_s_range : assert property (@(posedge clock) disable iff (reset)
      vld_ff[FB+1] && !sa_ff[FB].bad |-> s_pos <= (chi_pkg::SW)'(1 << FB))
      else $error("normalised position above one");

   a_rem_below : assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAT-2] && !rb_ff[DW].bad |-> rcell[DW].rem < rb_ff[DW].h)
      else $error("rate divider remainder not below divisor");

endmodule

// ===== tb/cubic_hermite_interpolator_top_tb.sv =====
// ----------------------------------------------------------------------------
// cubic_hermite_interpolator_top_tb
// Self-checking bench for the cubic Hermite segment interpolator. Segment
// queries are queued by a stimulus process, fed to the request channel by a
// clocked driver, and each response is checked field by field against a
// bit-exact Hermite evaluator held here, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cubic_hermite_interpolator_top_tb;

   typedef chi_pkg::word_type word_type;
   typedef logic signed [127:0] wide_type;

   typedef struct {
      word_type x1, x2, y1, y2, m1, m2, x, dx;
   } segment_query_type;

   typedef struct {
      word_type value;
      word_type rate;
      logic     bad;
   } hermite_result_type;

   localparam int       DW         = chi_pkg::DW;
   localparam int       FB         = chi_pkg::FB;
   localparam word_type WORD_MAX   = chi_pkg::WORD_MAX;
   localparam word_type WORD_MIN   = chi_pkg::WORD_MIN;
   localparam int       LATENCY    = DW + FB + 15;
   localparam int       CYCLE_MAX  = 400000;
   localparam wide_type ONE_W      = wide_type'(1) <<< FB;

   logic clock;
   logic reset;

   chi_req_if req_ch ();
   chi_rsp_if rsp_ch ();

   cubic_hermite_interpolator_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   segment_query_type  pending_q[$];
   hermite_result_type expected_q[$];

   int unsigned errors;
   int unsigned sent_count;
   int unsigned checked_count;
   int unsigned bad_seen;
   int unsigned sat_seen;
   int unsigned cycles;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned hold_left;
   int unsigned stall_seen;
   logic        hold_done;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic wide_type floor_div(input wide_type n, input wide_type d);
      wide_type q;
      q = n / d;
      if ((n % d) != 0 && n < 0) begin
         q = q - 1;
      end
      return q;
   endfunction

   function automatic word_type clip_word(input wide_type v);
      if (v > wide_type'(WORD_MAX)) begin
         return WORD_MAX;
      end else if (v < wide_type'(WORD_MIN)) begin
         return WORD_MIN;
      end
      return word_type'(v[DW-1:0]);
   endfunction

   function automatic hermite_result_type hermite_eval(input segment_query_type q);
      hermite_result_type r;
      wide_type x1, x2, y1, y2, m1, m2, x, dx;
      wide_type h, s, p1, p2, a0, a1, a2, t, y, d, gq, gr, rate, lim;
      x1 = wide_type'(q.x1);  x2 = wide_type'(q.x2);
      y1 = wide_type'(q.y1);  y2 = wide_type'(q.y2);
      m1 = wide_type'(q.m1);  m2 = wide_type'(q.m2);
      x  = wide_type'(q.x);   dx = wide_type'(q.dx);
      lim = wide_type'(1) <<< DW;
      if (x2 <= x1) begin
         r.value = '0;
         r.rate  = '0;
         r.bad   = 1'b1;
         return r;
      end
      h = x2 - x1;
      if (x < x1) x = x1;
      if (x > x2) x = x2;
      s  = ((x - x1) * ONE_W) / h;
      p1 = floor_div(m1 * h, ONE_W);
      p2 = floor_div(m2 * h, ONE_W);
      a0 = 2 * (y1 - y2) + p1 + p2;
      a1 = 3 * (y2 - y1) - 2 * p1 - p2;
      a2 = p1;
      // s is never negative, so floor(a*s/ONE) is the Horner product
      t = floor_div(a0 * s, ONE_W) + a1;
      t = floor_div(t * s, ONE_W) + a2;
      y = floor_div(t * s, ONE_W) + y1;
      t = floor_div(3 * a0 * s, ONE_W) + 2 * a1;
      d = floor_div(t * s, ONE_W) + a2;
      gq = floor_div(d, h);
      gr = d - gq * h;
      if (dx == 0) begin
         rate = 0;
      end else if (gq >= lim || gq <= -lim) begin
         rate = ((dx < 0) != (gq < 0)) ? wide_type'(WORD_MIN) : wide_type'(WORD_MAX);
      end else begin
         rate = dx * gq + floor_div(dx * gr, h);
      end
      r.value = clip_word(y);
      r.rate  = clip_word(rate);
      r.bad   = 1'b0;
      return r;
   endfunction

   function automatic word_type pick_word();
      case ($urandom_range(0, 9))
         0:       return WORD_MAX;
         1:       return WORD_MIN;
         2, 3:    return word_type'($urandom);
         default: return word_type'($urandom_range(0, 32'h1F_FFFF)) - word_type'(32'h10_0000);
      endcase
   endfunction

   function automatic segment_query_type random_query();
      segment_query_type q;
      longint x1, h, x;
      q.y1 = pick_word();
      q.y2 = pick_word();
      q.m1 = pick_word();
      q.m2 = pick_word();
      q.dx = ($urandom_range(0, 19) == 0) ? word_type'(0) : pick_word();
      x1 = longint'(pick_word());
      case ($urandom_range(0, 5))
         0:       h = 1 + $urandom_range(0, 15);
         1:       h = longint'($urandom) & 64'h7FFF_FFFF;
         default: h = 1 + $urandom_range(0, 32'h7_FFFF);
      endcase
      if ($urandom_range(0, 9) == 0) begin
         h = -(longint'($urandom_range(0, 32'h1_0000)));   // malformed segment
      end
      if (h > 0 && x1 + h > longint'(WORD_MAX)) begin
         x1 = longint'(WORD_MAX) - h;
      end
      case ($urandom_range(0, 7))
         0:       x = x1 - $urandom_range(1, 32'hFFFF);
         1:       x = x1 + h + $urandom_range(1, 32'hFFFF);
         default: x = (h > 0) ? x1 + longint'($urandom_range(0, 32'hFFFF_FFFF)) % (h + 1) : x1;
      endcase
      if ($urandom_range(0, 15) == 0) begin
         x = longint'(word_type'($urandom));
      end
      q.x1 = word_type'(x1);
      q.x2 = word_type'(x1 + h);
      q.x  = word_type'(x);
      return q;
   endfunction

   function automatic segment_query_type make_query(input word_type x1, x2, y1, y2,
                                                    m1, m2, x, dx);
      segment_query_type q;
      q.x1 = x1; q.x2 = x2; q.y1 = y1; q.y2 = y2;
      q.m1 = m1; q.m2 = m2; q.x  = x;  q.dx = dx;
      return q;
   endfunction

   task automatic report_mismatch(input string what, input logic [DW-1:0] exp_v,
                                  input logic [DW-1:0] got_v);
      errors++;
      $display("mismatch #%0d at result %0d: %s expected %h got %h",
               errors, checked_count, what, exp_v, got_v);
   endtask

   // request driver
   always @(posedge clock) begin
      segment_query_type q;
      logic              load;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         load = pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct;
         if (load) begin
            q = pending_q.pop_front();
            req_ch.seg_start   <= q.x1;
            req_ch.seg_end     <= q.x2;
            req_ch.val_start   <= q.y1;
            req_ch.val_end     <= q.y2;
            req_ch.slope_start <= q.m1;
            req_ch.slope_end   <= q.m2;
            req_ch.query_point <= q.x;
            req_ch.query_rate  <= q.dx;
            sent_count++;
         end
         req_ch.valid <= load;
      end
   end

   // long hold-off on the response side, once, mid-run
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && sent_count >= 400) begin
         hold_left <= 3 * LATENCY;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= hold_left == 0 && $urandom_range(0, 99) >= recv_idle_pct;
      end
   end

   // predict on request transactions, check on response transactions
   always @(posedge clock) begin
      hermite_result_type e;
      if (!reset) begin
         if (hold_left != 0 && req_ch.valid && !req_ch.ready) begin
            stall_seen++;
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_q.push_back(hermite_eval(make_query(
               req_ch.seg_start, req_ch.seg_end, req_ch.val_start, req_ch.val_end,
               req_ch.slope_start, req_ch.slope_end, req_ch.query_point,
               req_ch.query_rate)));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected transaction", '0, rsp_ch.value_out);
            end else begin
               e = expected_q.pop_front();
               if (rsp_ch.value_out !== e.value)
                  report_mismatch("value_out", e.value, rsp_ch.value_out);
               if (rsp_ch.rate_out !== e.rate)
                  report_mismatch("rate_out", e.rate, rsp_ch.rate_out);
               if (rsp_ch.bad_segment !== e.bad)
                  report_mismatch("bad_segment", DW'(e.bad), DW'(rsp_ch.bad_segment));
               if (e.bad) bad_seen++;
               if (e.value == WORD_MAX || e.value == WORD_MIN ||
                   e.rate == WORD_MAX || e.rate == WORD_MIN) sat_seen++;
            end
            checked_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_MAX) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, expected_q.size());
         $display("FAIL cubic_hermite_interpolator_top");
         $finish;
      end
   end

   initial begin
      word_type one;
      one = word_type'(1) <<< FB;
      errors = 0; sent_count = 0; checked_count = 0; cycles = 0;
      bad_seen = 0; sat_seen = 0; stall_seen = 0;
      send_idle_pct = 14;
      recv_idle_pct = 49;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.seg_start = '0;   req_ch.seg_end = '0;
      req_ch.val_start = '0;   req_ch.val_end = '0;
      req_ch.slope_start = '0; req_ch.slope_end = '0;
      req_ch.query_point = '0; req_ch.query_rate = '0;
      rsp_ch.ready = 1'b0;

      // directed: malformed segments, clamping, zero rate, extremes
      pending_q.push_back(make_query(one, one, one, -one, one, one, one, one));
      pending_q.push_back(make_query(one, -one, one, 0, 0, 0, 0, one));
      pending_q.push_back(make_query(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MAX,
                                     WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
      pending_q.push_back(make_query(0, one, 0, one, one, one, 0, one));
      pending_q.push_back(make_query(0, one, 0, one, one, one, one, one));
      pending_q.push_back(make_query(0, one, 0, one, one, one, one / 2, one));
      pending_q.push_back(make_query(0, one, 0, one, 0, 0, -one, -one));
      pending_q.push_back(make_query(0, one, 0, one, 0, 0, 4 * one, one));
      pending_q.push_back(make_query(0, one, one, -one, one, -one, one / 3, 0));
      pending_q.push_back(make_query(0, 1, one, -one, one, one, 0, one));
      pending_q.push_back(make_query(0, 1, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN,
                                     1, WORD_MAX));
      pending_q.push_back(make_query(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX,
                                     WORD_MAX, WORD_MAX, 0, WORD_MAX));
      pending_q.push_back(make_query(WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN,
                                     WORD_MIN, WORD_MIN, WORD_MIN / 2, WORD_MIN));
      pending_q.push_back(make_query(WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX,
                                     WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN));
      pending_q.push_back(make_query(WORD_MIN, WORD_MIN + 1, 0, 0, WORD_MAX,
                                     WORD_MIN, WORD_MIN, -1));
      pending_q.push_back(make_query(-one, one, WORD_MAX, WORD_MIN, 0, 0, 0, 1));
      pending_q.push_back(make_query(-one, one, 0, 0, WORD_MAX, WORD_MAX, 0,
                                     WORD_MAX));
      pending_q.push_back(make_query(-one, one, -1, -1, -1, -1, -1, -1));
      pending_q.push_back(make_query(WORD_MAX - 1, WORD_MAX, 1, 2, 3, 4,
                                     WORD_MAX, 5));
      pending_q.push_back(make_query(0, -1, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
                                     WORD_MAX, WORD_MAX));
      for (int i = 0; i < 1800; i++) begin
         pending_q.push_back(random_query());
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      wait (sent_count >= 620);
      send_idle_pct = 49;
      recv_idle_pct = 14;
      wait (sent_count >= 1220);
      send_idle_pct = 0;
      recv_idle_pct = 0;

      while (pending_q.size() != 0 || req_ch.valid || expected_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (LATENCY + 20) @(posedge clock);

      $display("checked %0d results: %0d malformed segments, %0d saturated outputs",
               checked_count, bad_seen, sat_seen);
      $display("request stalled %0d cycles under response hold-off", stall_seen);
      if (errors == 0) begin
         $display("PASS cubic_hermite_interpolator_top");
      end else begin
         $display("FAIL cubic_hermite_interpolator_top");
      end
      $finish;
   end

endmodule
